/* design/raq_pkg.sv */
// raq_pkg: shared constants, types and codes for the request admission queue.
// No dependencies.
package raq_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int WORKERS    = 4;
    localparam int TAG_BITS   = 16;
    localparam int WIDX_BITS  = $clog2(WAIT_DEPTH);
    localparam int CNT_BITS   = $clog2(WAIT_DEPTH + 1);
    localparam int WK_BITS    = 2;
    localparam int MAX_EVICT  = 8;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [2:0] CFG_POLICY  = 3'd0;
    localparam logic [2:0] CFG_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_CEILING = 3'd2;
    localparam logic [2:0] CFG_WORKERS = 3'd3;
    localparam logic [2:0] CFG_SEED    = 3'd4;

    localparam logic [2:0] POL_BLOCK       = 3'd0;
    localparam logic [2:0] POL_DROP_TAIL   = 3'd1;
    localparam logic [2:0] POL_DROP_HEAD   = 3'd2;
    localparam logic [2:0] POL_BLOCK_FLUSH = 3'd3;
    localparam logic [2:0] POL_DYNAMIC     = 3'd4;
    localparam logic [2:0] POL_DROP_RANDOM = 3'd5;

    localparam logic [1:0] ACT_ARRIVE   = 2'd0;
    localparam logic [1:0] ACT_DISPATCH = 2'd1;
    localparam logic [1:0] ACT_COMPLETE = 2'd2;

    localparam logic [3:0] ST_QUEUED      = 4'd0;
    localparam logic [3:0] ST_REFUSED     = 4'd1;
    localparam logic [3:0] ST_DROPPED     = 4'd2;
    localparam logic [3:0] ST_EVICTED     = 4'd3;
    localparam logic [3:0] ST_DISPATCHED  = 4'd4;
    localparam logic [3:0] ST_EMPTY       = 4'd5;
    localparam logic [3:0] ST_COMPLETED   = 4'd6;
    localparam logic [3:0] ST_NOT_RUNNING = 4'd7;
    localparam logic [3:0] ST_BUSY        = 4'd8;

    // Result tag sources.
    localparam logic [1:0] TSEL_INPUT   = 2'd0;
    localparam logic [1:0] TSEL_REMOVED = 2'd1;
    localparam logic [1:0] TSEL_RUNNING = 2'd2;
    localparam logic [1:0] TSEL_ZERO    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RAND_STEP, S_RAND_MOD, S_SHIFT, S_EMIT, S_WAIT_OUT
    } t_state;

    // Shift purposes: what follows a compaction.
    typedef enum logic [1:0] {
        K_NONE, K_HEAD, K_RAND, K_DISPATCH
    } t_kind;

    // Controller -> datapath commands.
    typedef struct packed {
        logic       load_in;
        logic       lfsr_step;
        logic       mod_start;
        logic       shift_start;   // begin removal at r_idx
        logic       shift_step;
        logic       use_mod_idx;   // removal index from modulo result, else 0
        logic       push;
        logic       run_set;
        logic       run_clr;
        logic       grow_limit;
        logic       set_flush;
        logic       clr_flush_chk;
        logic       out_load;
        logic [3:0] out_status;
        logic [1:0] out_tag_sel;   // one of the TSEL_ codes
        logic       out_wk_zero;
        logic       out_last;
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic [1:0] action;
        logic [2:0] policy;
        logic       flush;
        logic       under_limit;
        logic       at_cap;
        logic       storage_full;
        logic       wait_empty;
        logic       wk_oob;
        logic       wk_busy;
        logic [3:0] evict_n;
        logic       mod_done;
        logic       shift_done;
        logic       out_busy;
    } t_stat;

endpackage

/* design/request_admission_queue.sv */
// request_admission_queue: top level; event sequencer plus queue datapath.
// Depends on raq_pkg, raq_ctrl, raq_dp.
//
// One event at a time. Arrival, completion and simple dispatch: the word is captured,
// then decided and its result word registered, and the sequencer is idle again. Dispatch
// and drop head compact the FIFO one entry per cycle. Drop random: per eviction a
// bit-serial modulo, then compaction and a result word, at most 8 evictions. A stalled
// result word holds the sequencer.
// Synchronous active-low reset: FIFO empty, no worker running, limit and LFSR
// loaded from register reset values; waiting and running tags undefined.
module request_admission_queue import raq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // action[1:0], request_tag[17:2], worker_id[19:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[3:0], result_tag[19:4], result_worker[21:20]
    output logic        m_axis_tlast
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle;
    logic [3:0]          w_status;
    logic [TAG_BITS-1:0] w_tag;
    logic [1:0]          w_wk;

    // accept a word only while the sequencer is idle
    assign s_axis_tready = w_idle;

    raq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_axis_tvalid && w_idle),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_idle  (w_idle)
    );

    raq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_action   (s_axis_tdata[1:0]),
        .i_tag      (s_axis_tdata[17:2]),
        .i_worker   (s_axis_tdata[19:18]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (w_status),
        .o_tag      (w_tag),
        .o_worker   (w_wk),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_wk, w_tag, w_status};

endmodule

/* design/raq_ctrl.sv */
// raq_ctrl: event sequencer for the request admission queue.
// Depends on raq_pkg.
module raq_ctrl import raq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output logic   o_idle
);

    t_state     r_state, n_state;
    t_kind      r_kind, n_kind;
    logic [3:0] r_left, n_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_NONE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_left  = r_left;
        o_cmd   = '0;
        o_idle  = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    priority case (i_stat.action)
                        ACT_ARRIVE: begin
                            o_cmd.clr_flush_chk = 1'b1;
                            priority if (i_stat.flush && i_stat.policy == POL_BLOCK_FLUSH) begin
                                o_cmd.out_status = ST_REFUSED;
                            end else if (i_stat.under_limit) begin
                                o_cmd.push = !i_stat.storage_full;
                                o_cmd.out_status = !i_stat.storage_full ? ST_QUEUED :
                                    (i_stat.policy == POL_BLOCK ? ST_REFUSED : ST_DROPPED);
                            end else if (i_stat.policy == POL_BLOCK) begin
                                o_cmd.push = !i_stat.at_cap && !i_stat.storage_full;
                                o_cmd.out_status = o_cmd.push ? ST_QUEUED : ST_REFUSED;
                            end else if (i_stat.policy == POL_DROP_HEAD) begin
                                if (i_stat.wait_empty) begin
                                    o_cmd.out_status = ST_DROPPED;
                                end else begin
                                    o_cmd.out_load    = 1'b0;
                                    o_cmd.shift_start = 1'b1;
                                    n_kind  = K_HEAD;
                                    n_state = S_SHIFT;
                                end
                            end else if (i_stat.policy == POL_BLOCK_FLUSH) begin
                                o_cmd.set_flush  = 1'b1;
                                o_cmd.out_status = ST_REFUSED;
                            end else if (i_stat.policy == POL_DYNAMIC) begin
                                o_cmd.grow_limit = 1'b1;
                                o_cmd.out_status = ST_DROPPED;
                            end else if (i_stat.policy == POL_DROP_RANDOM) begin
                                o_cmd.out_load = 1'b0;
                                n_left  = i_stat.evict_n;
                                n_kind  = K_RAND;
                                n_state = S_RAND_STEP;
                            end else begin
                                o_cmd.out_status = ST_DROPPED;
                            end
                        end
                        ACT_DISPATCH: begin
                            priority if (i_stat.wk_oob) begin
                                o_cmd.out_status  = ST_BUSY;
                                o_cmd.out_tag_sel = TSEL_ZERO;
                            end else if (i_stat.wk_busy) begin
                                o_cmd.out_status  = ST_BUSY;
                                o_cmd.out_tag_sel = TSEL_RUNNING;
                            end else if (i_stat.wait_empty) begin
                                o_cmd.out_status  = ST_EMPTY;
                                o_cmd.out_tag_sel = TSEL_ZERO;
                            end else begin
                                o_cmd.out_load    = 1'b0;
                                o_cmd.shift_start = 1'b1;
                                n_kind  = K_DISPATCH;
                                n_state = S_SHIFT;
                            end
                        end
                        ACT_COMPLETE: begin
                            if (!i_stat.wk_oob && i_stat.wk_busy) begin
                                o_cmd.run_clr     = 1'b1;
                                o_cmd.out_status  = ST_COMPLETED;
                                o_cmd.out_tag_sel = TSEL_RUNNING;
                            end else begin
                                o_cmd.out_status  = ST_NOT_RUNNING;
                                o_cmd.out_tag_sel = TSEL_ZERO;
                            end
                        end
                        default: begin
                            o_cmd.out_status  = ST_EMPTY;
                            o_cmd.out_tag_sel = TSEL_ZERO;
                            o_cmd.out_wk_zero = 1'b1;
                        end
                    endcase
                end
            end
            S_RAND_STEP: begin
                // evictions done or FIFO drained: emit the arrival, queued unless the FIFO is full
                if (r_left == '0 || i_stat.wait_empty) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.lfsr_step = 1'b1;
                    o_cmd.mod_start = 1'b1;
                    n_left  = r_left - 4'd1;
                    n_state = S_RAND_MOD;
                end
            end
            S_RAND_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.shift_start = 1'b1;
                    o_cmd.use_mod_idx = 1'b1;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_WAIT_OUT;
                end
            end
            S_WAIT_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_tag_sel = TSEL_REMOVED;
                    if (r_kind == K_DISPATCH) begin
                        o_cmd.run_set    = 1'b1;
                        o_cmd.out_status = ST_DISPATCHED;
                        o_cmd.out_last   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_status = ST_EVICTED;
                        n_state = (r_kind == K_RAND) ? S_RAND_STEP : S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.push       = !i_stat.storage_full;
                    o_cmd.out_status = i_stat.storage_full ? ST_DROPPED : ST_QUEUED;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(o_cmd.push && o_cmd.shift_start)) else $error("push during removal");
            assert (!(o_cmd.run_set && o_cmd.run_clr)) else $error("run set and clear");
        end
    end

    a_out_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy) else $error("result overwritten");
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> r_state == S_DECIDE) else $error("bad start");
    a_rand_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RAND_STEP |-> r_left <= 4'(MAX_EVICT)) else $error("evict count");

endmodule

/* design/raq_dp.sv */
// raq_dp: waiting FIFO, running table, limits, LFSR, modulo unit and result register.
// Depends on raq_pkg.
module raq_dp import raq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [15:0]         i_cfg_data,
    input  logic [1:0]          i_action,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic [1:0]          i_worker,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_status,
    output logic [TAG_BITS-1:0] o_tag,
    output logic [1:0]          o_worker,
    output logic                o_last
);

    logic [2:0]  r_policy;
    logic [4:0]  r_total, r_ceil, r_limit;
    logic [2:0]  r_wcnt;
    logic [15:0] r_seed, r_lfsr;
    logic        r_flush;

    logic [1:0]          r_action;
    logic [TAG_BITS-1:0] r_tag;
    logic [1:0]          r_wk;

    logic [TAG_BITS-1:0] r_wait [WAIT_DEPTH];
    logic [CNT_BITS-1:0] r_count;
    logic [TAG_BITS-1:0] r_run [WORKERS];
    logic [WORKERS-1:0]  r_run_v;

    logic [WIDX_BITS-1:0] r_idx;
    logic [TAG_BITS-1:0]  r_removed;
    logic                 r_shifting, r_shift_done;

    logic [16:0]         r_rem;
    logic [4:0]          r_mod_bit;
    logic                r_mod_busy;
    logic [CNT_BITS-1:0] r_div;

    logic                r_ovalid;
    logic [3:0]          r_ostatus;
    logic [TAG_BITS-1:0] r_otag;
    logic [1:0]          r_owk;
    logic                r_olast;

    logic [5:0] w_cap_raw;
    logic [4:0] w_cap;
    logic [2:0] w_running;
    logic [5:0] w_occ;
    logic [5:0] w_ceil;
    logic [15:0] w_lfsr_src, w_lfsr_nx;
    logic        w_run_hit;
    logic [16:0] w_rem_sh;

    // waiting capacity = limit - workers, clamped to [0, WAIT_DEPTH]
    always_comb begin
        w_cap_raw = (r_limit > 5'(r_wcnt)) ? 6'(r_limit - 5'(r_wcnt)) : 6'd0;
        w_cap = (w_cap_raw > 6'(WAIT_DEPTH)) ? 5'(WAIT_DEPTH) : w_cap_raw[4:0];
        w_running = '0;
        for (int i = 0; i < WORKERS; i++) w_running = w_running + 3'(r_run_v[i]);
        w_occ  = 6'(r_count) + 6'(w_running);
        w_ceil = 6'(r_ceil);
        if (w_ceil > 6'(WAIT_DEPTH) + 6'(r_wcnt)) w_ceil = 6'(WAIT_DEPTH) + 6'(r_wcnt);
        if (w_ceil > 6'd31) w_ceil = 6'd31;
        w_lfsr_src = (r_lfsr == 16'd0) ? 16'd1 : r_lfsr;
        w_lfsr_nx  = w_lfsr_src[0] ? ((w_lfsr_src >> 1) ^ LFSR_TAPS) : (w_lfsr_src >> 1);
        w_run_hit  = (32'(r_wk) < WORKERS) && r_run_v[r_wk];
        w_rem_sh   = {r_rem[15:0], r_lfsr[r_mod_bit[3:0]]};
    end

    always_comb begin
        o_stat.action       = r_action;
        o_stat.policy       = r_policy;
        o_stat.flush        = r_flush && !(r_count == '0 && r_run_v == '0);
        o_stat.under_limit  = w_occ < 6'(r_limit);
        o_stat.at_cap       = 5'(r_count) >= w_cap;
        o_stat.storage_full = r_count >= CNT_BITS'(WAIT_DEPTH);
        o_stat.wait_empty   = r_count == '0;
        o_stat.wk_oob       = 32'(r_wk) >= WORKERS;
        o_stat.wk_busy      = w_run_hit;
        o_stat.evict_n      = (w_cap[4:1] > 4'(MAX_EVICT)) ? 4'(MAX_EVICT) : w_cap[4:1];
        o_stat.mod_done     = !r_mod_busy;
        o_stat.shift_done   = r_shift_done;
        o_stat.out_busy     = r_ovalid && !i_ready;
    end

    // configuration and limit/seed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_BLOCK;
            r_total  <= 5'd20;
            r_limit  <= 5'd20;
            r_ceil   <= 5'd20;
            r_wcnt   <= 3'd4;
            r_seed   <= 16'd44257;
            r_lfsr   <= 16'd44257;
            r_flush  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_POLICY:  r_policy <= i_cfg_data[2:0];
                    CFG_LIMIT: begin
                        r_total <= i_cfg_data[4:0];
                        r_limit <= i_cfg_data[4:0];
                    end
                    CFG_CEILING: r_ceil <= i_cfg_data[4:0];
                    CFG_WORKERS: r_wcnt <= i_cfg_data[2:0];
                    CFG_SEED: begin
                        r_seed <= i_cfg_data;
                        r_lfsr <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.lfsr_step) r_lfsr <= w_lfsr_nx;
            if (i_cmd.grow_limit && 6'(r_limit) < w_ceil) r_limit <= r_limit + 5'd1;
            if (i_cmd.clr_flush_chk && r_count == '0 && r_run_v == '0) r_flush <= 1'b0;
            if (i_cmd.set_flush) r_flush <= 1'b1;
            if (i_cmd.run_clr && r_count == '0 && (r_run_v & ~(WORKERS'(1) << r_wk)) == '0)
                r_flush <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_tag    <= i_tag;
            r_wk     <= i_worker;
        end
    end

    // bit-serial modulo: lfsr % count, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_busy <= 1'b0;
            r_mod_bit  <= '0;
            r_rem      <= '0;
            r_div      <= '0;
        end else if (i_cmd.mod_start) begin
            r_mod_busy <= 1'b1;
            r_mod_bit  <= 5'd15;
            r_rem      <= '0;
            r_div      <= r_count;
        end else if (r_mod_busy) begin
            r_rem <= (w_rem_sh >= 17'(r_div)) ? w_rem_sh - 17'(r_div) : w_rem_sh;
            r_mod_bit <= r_mod_bit - 5'd1;
            if (r_mod_bit == 5'd0) r_mod_busy <= 1'b0;
        end
    end

    // FIFO: push at tail, removal by compaction one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_shifting   <= 1'b0;
            r_shift_done <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_shift_done <= 1'b0;
            if (i_cmd.push) r_count <= r_count + CNT_BITS'(1);
            if (i_cmd.shift_start) begin
                r_shifting <= 1'b1;
                r_idx <= i_cmd.use_mod_idx ? r_rem[WIDX_BITS-1:0] : '0;
            end else if (r_shifting) begin
                if (CNT_BITS'(r_idx) + CNT_BITS'(1) < r_count) begin
                    r_idx <= r_idx + WIDX_BITS'(1);
                end else begin
                    r_shifting   <= 1'b0;
                    r_shift_done <= 1'b1;
                    r_count      <= r_count - CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_wait[r_count[WIDX_BITS-1:0]] <= r_tag;
        if (i_cmd.shift_start)
            r_removed <= r_wait[i_cmd.use_mod_idx ? r_rem[WIDX_BITS-1:0] : WIDX_BITS'(0)];
        else if (r_shifting && CNT_BITS'(r_idx) + CNT_BITS'(1) < r_count)
            r_wait[r_idx] <= r_wait[r_idx + WIDX_BITS'(1)];
    end

    // running table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_v <= '0;
        end else begin
            if (i_cmd.run_set) r_run_v[r_wk] <= 1'b1;
            if (i_cmd.run_clr) r_run_v[r_wk] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_set) r_run[r_wk] <= r_removed;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.out_status;
            r_olast   <= i_cmd.out_last;
            r_owk     <= (r_action == ACT_ARRIVE || i_cmd.out_wk_zero) ? 2'd0 : r_wk;
            unique case (i_cmd.out_tag_sel)
                TSEL_INPUT:   r_otag <= r_tag;
                TSEL_REMOVED: r_otag <= r_removed;
                TSEL_RUNNING: r_otag <= r_run[r_wk];
                default:      r_otag <= '0;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_tag    = r_otag;
    assign o_worker = r_owk;
    assign o_last   = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(WAIT_DEPTH)) else $error("FIFO overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_count < CNT_BITS'(WAIT_DEPTH)) else $error("push into full FIFO");
    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_start |-> r_count != '0) else $error("removal from empty FIFO");

endmodule
